[hdl/anchor_box_decoder_core_assert.svh]
// Assertion macros shared by the anchor box decoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ANCHOR_BOX_DECODER_CORE_ASSERT_SVH
`define ANCHOR_BOX_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define ABD_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define ABD_ASSERT_NXT(name, ck, rn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/abd_pkg.sv]
// Shared types, constants and table functions for the anchor box decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package abd_pkg;

  localparam int ANCHOR_COUNT = 3;
  localparam int MAX_CLASSES = 80;
  localparam int BASE_GRID   = 80;
  localparam int ELEM_CAP    = 122;
  localparam int CLASS_LIMIT = (MAX_CLASSES < ELEM_CAP) ? MAX_CLASSES : ELEM_CAP;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] REG_SCALE     = 3'd0;
  localparam logic [2:0] REG_CLASSES   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_HFACTOR   = 3'd3;
  localparam logic [2:0] REG_VFACTOR   = 3'd4;

  localparam logic [1:0] SCALE_SMALL  = 2'd0;
  localparam logic [1:0] SCALE_MIDDLE = 2'd1;
  localparam logic [1:0] SCALE_LARGE  = 2'd2;
  localparam logic [1:0] SCALE_UNUSED = 2'd3;

  localparam logic [18:0] COORD_MAX = 19'h7FFFF;

  typedef struct packed {
    logic [15:0] s0;
    logic [15:0] s1;
    logic [15:0] s2;
    logic [15:0] s3;
    logic [15:0] so;
    logic [15:0] sc;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [1:0]  anchor;
    logic [6:0]  cls;
  } job_t;

  typedef struct packed {
    logic [18:0] box_left;
    logic [18:0] box_top;
    logic [18:0] box_width;
    logic [18:0] box_height;
    logic [15:0] objectness;
    logic [15:0] class_probability;
    logic [6:0]  class_number;
  } result_t;

  function automatic logic [16:0] sig_entry(input logic [4:0] k);
    logic [16:0] t;
    case (k)
      5'd0:  t = 17'd32768;
      5'd1:  t = 17'd40793;
      5'd2:  t = 17'd47911;
      5'd3:  t = 17'd53581;
      5'd4:  t = 17'd57724;
      5'd5:  t = 17'd60565;
      5'd6:  t = 17'd62428;
      5'd7:  t = 17'd63615;
      5'd8:  t = 17'd64357;
      5'd9:  t = 17'd64816;
      5'd10: t = 17'd65097;
      5'd11: t = 17'd65269;
      5'd12: t = 17'd65374;
      5'd13: t = 17'd65438;
      5'd14: t = 17'd65476;
      5'd15: t = 17'd65500;
      5'd16: t = 17'd65514;
      5'd17: t = 17'd65523;
      5'd18: t = 17'd65528;
      5'd19: t = 17'd65531;
      5'd20: t = 17'd65533;
      5'd21: t = 17'd65534;
      5'd22: t = 17'd65535;
      5'd23: t = 17'd65535;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] sigmoid_q16(input logic [15:0] v);
    logic [16:0] m;
    logic [16:0] p;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [4:0]  k;
    logic [6:0]  f;
    logic [12:0] dlt;
    logic [19:0] prod;
    logic [15:0] r;
    m = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    k = m[11:7];
    f = m[6:0];
    t0 = sig_entry(k);
    t1 = sig_entry(k + 5'd1);
    dlt = 13'(t1 - t0);
    prod = 20'(dlt) * 20'(f) + 20'd64;
    if (m >= 17'd3072) begin
      p = 17'h10000;
    end else begin
      p = t0 + 17'(prod[19:7]);
    end
    if (v[15]) begin
      r = 16'(17'h10000 - p);
    end else begin
      r = p[16] ? 16'hFFFF : p[15:0];
    end
    return r;
  endfunction

  function automatic logic [8:0] anchor_size(input logic [1:0] scale, input logic [2:0] idx);
    logic [8:0] a;
    a = 9'd0;
    case (scale)
      SCALE_SMALL: begin
        case (idx)
          3'd0: a = 9'd10;
          3'd1: a = 9'd13;
          3'd2: a = 9'd16;
          3'd3: a = 9'd30;
          3'd4: a = 9'd33;
          default: a = 9'd23;
        endcase
      end
      SCALE_MIDDLE: begin
        case (idx)
          3'd0: a = 9'd30;
          3'd1: a = 9'd61;
          3'd2: a = 9'd62;
          3'd3: a = 9'd45;
          3'd4: a = 9'd59;
          default: a = 9'd119;
        endcase
      end
      SCALE_LARGE: begin
        case (idx)
          3'd0: a = 9'd116;
          3'd1: a = 9'd90;
          3'd2: a = 9'd156;
          3'd3: a = 9'd198;
          3'd4: a = 9'd373;
          default: a = 9'd326;
        endcase
      end
      default: a = 9'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hdl/abd_front.sv]
// Front end: position counters, sigmoid lookup, record store and score test.
// Depends on abd_pkg; feeds passing class values to the job queue.
`default_nettype none

`include "anchor_box_decoder_core_assert.svh"

module abd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [15:0]   logit,
  input  wire logic          map_start,
  input  wire logic [1:0]    scale,
  input  wire logic [6:0]    class_count,
  input  wire logic [15:0]   threshold,
  input  wire logic          q_full,
  output logic               q_wr_en,
  output abd_pkg::job_t      q_wr_data
);
  import abd_pkg::*;

  logic [6:0]  elem_r, elem_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [6:0]  row_r, row_nxt;
  logic [1:0]  anc_r, anc_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_sig_r;
  logic [2:0]  s1_idx_r;
  logic [6:0]  s1_cls_r;
  logic [6:0]  s1_col_r;
  logic [6:0]  s1_row_r;
  logic [1:0]  s1_anc_r;
  logic        s1_is_rec_r;
  logic        s1_is_cls_r;

  logic [15:0] rec_r [5];

  logic        accept;
  logic        s1_go;
  logic        s1_push;
  logic        pass;
  logic [31:0] score;
  logic [6:0]  classes;
  logic [6:0]  grid;
  logic [6:0]  e_cur, c_cur, r_cur;
  logic [1:0]  a_cur;
  logic        is_rec, is_cls;
  logic [6:0]  cls_num;

  always_comb begin
    classes = (class_count > 7'(CLASS_LIMIT)) ? 7'(CLASS_LIMIT) : class_count;
    case (scale)
      SCALE_SMALL:  grid = 7'(BASE_GRID);
      SCALE_MIDDLE: grid = 7'(BASE_GRID >> 1);
      default:      grid = 7'(BASE_GRID >> 2);
    endcase
  end

  assign score   = 32'(s1_sig_r) * 32'(rec_r[4]);
  assign pass    = score > {threshold, 16'h0000};
  assign s1_push = s1_valid_r && s1_is_cls_r && pass;
  assign s1_go   = !s1_push || !q_full;
  assign full    = s1_valid_r && !s1_go;
  assign accept  = push && !full;
  assign q_wr_en = s1_push && !q_full;

  always_comb begin
    e_cur   = map_start ? 7'd0 : elem_r;
    c_cur   = map_start ? 7'd0 : col_r;
    r_cur   = map_start ? 7'd0 : row_r;
    a_cur   = map_start ? 2'd0 : anc_r;
    is_rec  = e_cur < 7'd5;
    cls_num = e_cur - 7'd5;
    is_cls  = !is_rec && (cls_num < classes) && (scale != SCALE_UNUSED);

    elem_nxt = elem_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    anc_nxt  = anc_r;
    if (accept) begin
      elem_nxt = e_cur + 7'd1;
      col_nxt  = c_cur;
      row_nxt  = r_cur;
      anc_nxt  = a_cur;
      if ({1'b0, e_cur} + 8'd1 >= 8'd5 + {1'b0, classes}) begin
        elem_nxt = 7'd0;
        if ({1'b0, c_cur} + 8'd1 >= {1'b0, grid}) begin
          col_nxt = 7'd0;
          if ({1'b0, r_cur} + 8'd1 >= {1'b0, grid}) begin
            row_nxt = 7'd0;
            if ({1'b0, a_cur} + 3'd1 >= 3'(ANCHOR_COUNT)) begin
              anc_nxt = 2'd0;
            end else begin
              anc_nxt = a_cur + 2'd1;
            end
          end else begin
            row_nxt = r_cur + 7'd1;
          end
        end else begin
          col_nxt = c_cur + 7'd1;
        end
      end
    end

    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_r     <= 7'd0;
      col_r      <= 7'd0;
      row_r      <= 7'd0;
      anc_r      <= 2'd0;
      s1_valid_r <= 1'b0;
    end else begin
      elem_r     <= elem_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      anc_r      <= anc_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sig_r    <= sigmoid_q16(logit);
      s1_idx_r    <= e_cur[2:0];
      s1_cls_r    <= cls_num;
      s1_col_r    <= c_cur;
      s1_row_r    <= r_cur;
      s1_anc_r    <= a_cur;
      s1_is_rec_r <= is_rec;
      s1_is_cls_r <= is_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_is_rec_r) begin
      case (s1_idx_r)
        3'd0:    rec_r[0] <= s1_sig_r;
        3'd1:    rec_r[1] <= s1_sig_r;
        3'd2:    rec_r[2] <= s1_sig_r;
        3'd3:    rec_r[3] <= s1_sig_r;
        default: rec_r[4] <= s1_sig_r;
      endcase
    end
  end

  always_comb begin
    q_wr_data.s0     = rec_r[0];
    q_wr_data.s1     = rec_r[1];
    q_wr_data.s2     = rec_r[2];
    q_wr_data.s3     = rec_r[3];
    q_wr_data.so     = rec_r[4];
    q_wr_data.sc     = s1_sig_r;
    q_wr_data.col    = s1_col_r;
    q_wr_data.row    = s1_row_r;
    q_wr_data.anchor = s1_anc_r;
    q_wr_data.cls    = s1_cls_r;
  end

  `ABD_ASSERT_IMP(a_push_only_class, clk, rst_n, q_wr_en, s1_valid_r && s1_is_cls_r, "job pushed for a non-class value")

endmodule

`default_nettype wire

[hdl/abd_queue.sv]
// Short job queue between the front end and the box arithmetic sequencer.
// Depends on abd_pkg for the job type and depth.
`default_nettype none

`include "anchor_box_decoder_core_assert.svh"

module abd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  abd_pkg::job_t      wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output abd_pkg::job_t      rd_data,
  output logic               empty
);
  import abd_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_wr, do_rd;

  assign full    = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ABD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= (QUEUE_AW + 1)'(QUEUE_DEPTH), "queue count beyond depth")
  `ABD_ASSERT_IMP(a_no_overflow, clk, rst_n, wr_en, !full, "job written into a full queue")

endmodule

`default_nettype wire

[hdl/abd_back.sv]
// Box arithmetic: a step sequencer around one shared multiplier, plus the
// result register. Depends on abd_pkg; takes jobs from abd_queue.
`default_nettype none

`include "anchor_box_decoder_core_assert.svh"

module abd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  output logic               q_rd_en,
  input  abd_pkg::job_t      q_data,
  input  wire logic [1:0]    scale,
  input  wire logic [15:0]   hfactor,
  input  wire logic [15:0]   vfactor,
  output logic               res_valid,
  output abd_pkg::result_t   res_data,
  input  wire logic          res_pop
);
  import abd_pkg::*;

  localparam logic [3:0] STEP_SQ_W   = 4'd0;
  localparam logic [3:0] STEP_SQ_H   = 4'd1;
  localparam logic [3:0] STEP_SZ_W   = 4'd2;
  localparam logic [3:0] STEP_SZ_H   = 4'd3;
  localparam logic [3:0] STEP_OUT_W  = 4'd4;
  localparam logic [3:0] STEP_OUT_H  = 4'd5;
  localparam logic [3:0] STEP_EDGE_X = 4'd6;
  localparam logic [3:0] STEP_EDGE_Y = 4'd7;
  localparam logic [3:0] STEP_LEFT   = 4'd8;
  localparam logic [3:0] STEP_TOP    = 4'd9;

  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        res_valid_r, res_valid_nxt;
  job_t        job_r;
  result_t     res_r;
  logic [17:0] sq_w_r, sq_h_r;
  logic [26:0] w16_r, h16_r;
  logic [18:0] wo_r, ho_r, lo_r;
  logic [30:0] ex_r, ey_r;

  logic [30:0] mul_a;
  logic [16:0] mul_b;
  logic [47:0] prod;
  logic        slot_free;
  logic        res_load;
  logic [18:0] size_sat;
  logic [18:0] edge_sat;

  function automatic logic [30:0] edge17(input logic [15:0] s, input logic [6:0] pos,
                                         input logic [1:0] sc, input logic [26:0] size);
    logic signed [25:0] base;
    logic signed [31:0] c16;
    logic signed [32:0] e17;
    logic [2:0]         shamt;
    logic [30:0]        r;
    base  = $signed({3'b000, pos, 16'h0000}) + $signed({9'b0, s, 1'b0}) - 26'sd32768;
    shamt = 3'd3 + {1'b0, sc};
    c16   = $signed({{6{base[25]}}, base}) <<< shamt;
    e17   = $signed({c16, 1'b0}) - $signed({6'b0, size});
    r     = e17[32] ? 31'd0 : e17[30:0];
    return r;
  endfunction

  assign slot_free = !res_valid_r || res_pop;
  assign res_load  = busy_r && (step_r == STEP_TOP) && slot_free;
  assign q_rd_en   = !busy_r && !q_empty;
  assign res_valid = res_valid_r;
  assign res_data  = res_r;
  assign prod      = 48'(mul_a) * 48'(mul_b);
  assign size_sat  = (|prod[47:43]) ? COORD_MAX : prod[42:24];
  assign edge_sat  = (|prod[47:44]) ? COORD_MAX : prod[43:25];

  always_comb begin
    case (step_r)
      STEP_SQ_W: begin
        mul_a = {14'd0, job_r.s2, 1'b0};
        mul_b = {job_r.s2, 1'b0};
      end
      STEP_SQ_H: begin
        mul_a = {14'd0, job_r.s3, 1'b0};
        mul_b = {job_r.s3, 1'b0};
      end
      STEP_SZ_W: begin
        mul_a = {13'd0, sq_w_r};
        mul_b = {8'd0, anchor_size(scale, {job_r.anchor, 1'b0})};
      end
      STEP_SZ_H: begin
        mul_a = {13'd0, sq_h_r};
        mul_b = {8'd0, anchor_size(scale, {job_r.anchor, 1'b1})};
      end
      STEP_OUT_W: begin
        mul_a = {4'd0, w16_r};
        mul_b = {1'b0, hfactor};
      end
      STEP_OUT_H: begin
        mul_a = {4'd0, h16_r};
        mul_b = {1'b0, vfactor};
      end
      STEP_LEFT: begin
        mul_a = ex_r;
        mul_b = {1'b0, hfactor};
      end
      STEP_TOP: begin
        mul_a = ey_r;
        mul_b = {1'b0, vfactor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (q_rd_en) begin
        busy_nxt = 1'b1;
        step_nxt = STEP_SQ_W;
      end
    end else if (step_r != STEP_TOP) begin
      step_nxt = step_r + 4'd1;
    end else if (slot_free) begin
      busy_nxt = 1'b0;
    end

    if (res_load) begin
      res_valid_nxt = 1'b1;
    end else if (res_pop) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= STEP_SQ_W;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      job_r <= q_data;
    end
    if (busy_r) begin
      case (step_r)
        STEP_SQ_W:   sq_w_r <= prod[33:16];
        STEP_SQ_H:   sq_h_r <= prod[33:16];
        STEP_SZ_W:   w16_r  <= prod[26:0];
        STEP_SZ_H:   h16_r  <= prod[26:0];
        STEP_OUT_W:  wo_r   <= size_sat;
        STEP_OUT_H:  ho_r   <= size_sat;
        STEP_EDGE_X: ex_r   <= edge17(job_r.s0, job_r.col, scale, w16_r);
        STEP_EDGE_Y: ey_r   <= edge17(job_r.s1, job_r.row, scale, h16_r);
        STEP_LEFT:   lo_r   <= edge_sat;
        default: begin
        end
      endcase
    end
    if (res_load) begin
      res_r.box_left          <= lo_r;
      res_r.box_top           <= edge_sat;
      res_r.box_width         <= wo_r;
      res_r.box_height        <= ho_r;
      res_r.objectness        <= job_r.so;
      res_r.class_probability <= job_r.sc;
      res_r.class_number      <= job_r.cls;
    end
  end

  `ABD_ASSERT_IMP(a_step_bound, clk, rst_n, 1'b1, step_r <= STEP_TOP, "sequencer step out of range")
  `ABD_ASSERT_IMP(a_load_free, clk, rst_n, res_load, !res_valid_r || res_pop, "result overwritten before transaction")

endmodule

`default_nettype wire

[hdl/anchor_box_decoder_core.sv]
// Anchor box decoder top level: configuration registers and the front end,
// job queue and box sequencer. Depends on abd_pkg, abd_front, abd_queue, abd_back.
//
// One head value is taken per clock while the four-entry job queue has room;
// values that yield no box never hold the input. Each value whose class score
// passes the threshold becomes a job for the box sequencer, whose single shared
// multiplier works through ten steps per box and takes a new job only when idle,
// so a run of more than five passing classes in a row stalls the input. The
// result register lets the sequencer start on the next box while the current
// one waits to be popped.
`default_nettype none

module anchor_box_decoder_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [15:0]   in_logit,
  input  wire logic          in_map_start,
  output logic               empty,
  input  wire logic          pop,
  output logic [18:0]        out_box_left,
  output logic [18:0]        out_box_top,
  output logic [18:0]        out_box_width,
  output logic [18:0]        out_box_height,
  output logic [15:0]        out_objectness,
  output logic [15:0]        out_class_probability,
  output logic [6:0]         out_class_number,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import abd_pkg::*;

  logic [1:0]  scale_r;
  logic [6:0]  classes_r;
  logic [15:0] thresh_r;
  logic [15:0] hfactor_r;
  logic [15:0] vfactor_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  logic        q_full, q_empty, q_wr_en, q_rd_en;
  job_t        q_wr_data, q_rd_data;
  logic        res_valid;
  result_t     res_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 2'd0;
      classes_r <= 7'd80;
      thresh_r  <= 16'd16384;
      hfactor_r <= 16'd4096;
      vfactor_r <= 16'd4096;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCALE:     scale_r   <= pwdata[1:0];
        REG_CLASSES:   classes_r <= pwdata[6:0];
        REG_THRESHOLD: thresh_r  <= pwdata[15:0];
        REG_HFACTOR:   hfactor_r <= pwdata[15:0];
        REG_VFACTOR:   vfactor_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE:     prdata = {30'd0, scale_r};
      REG_CLASSES:   prdata = {25'd0, classes_r};
      REG_THRESHOLD: prdata = {16'd0, thresh_r};
      REG_HFACTOR:   prdata = {16'd0, hfactor_r};
      REG_VFACTOR:   prdata = {16'd0, vfactor_r};
      default:       prdata = 32'd0;
    endcase
  end

  abd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .logit       (in_logit),
    .map_start   (in_map_start),
    .scale       (scale_r),
    .class_count (classes_r),
    .threshold   (thresh_r),
    .q_full      (q_full),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data)
  );

  abd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  abd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rd_en   (q_rd_en),
    .q_data    (q_rd_data),
    .scale     (scale_r),
    .hfactor   (hfactor_r),
    .vfactor   (vfactor_r),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_pop   (pop)
  );

  assign empty                 = !res_valid;
  assign out_box_left          = res_data.box_left;
  assign out_box_top           = res_data.box_top;
  assign out_box_width         = res_data.box_width;
  assign out_box_height        = res_data.box_height;
  assign out_objectness        = res_data.objectness;
  assign out_class_probability = res_data.class_probability;
  assign out_class_number      = res_data.class_number;

endmodule

`default_nettype wire
